[src/dls_pkg.sv]
// Shared types and constants for the base-10000 limb short divider.
package dls_pkg;

    localparam int LIMB_W    = 14;
    localparam int PART_W    = 2 * LIMB_W;
    localparam int DIV_STEPS = PART_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int PADDR_W   = 3;

    localparam logic [LIMB_W-1:0]  LIMB_BASE   = LIMB_W'(10000);
    localparam logic [LIMB_W-1:0]  LIMB_ONES   = '1;
    localparam logic [LIMB_W-1:0]  DIVISOR_RST = LIMB_W'(1);
    localparam logic [PADDR_W-1:0] ADDR_DIVISOR = PADDR_W'(0);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    typedef struct packed {
        logic [LIMB_W-1:0] acc;
        logic [1:0]        qbits;
    } t_step_res;

endpackage

[src/dls_step2.sv]
// Two restoring-division steps: shift in two dividend bits, trial-subtract twice.
module dls_step2 (
    input  logic [dls_pkg::LIMB_W-1:0] i_acc,
    input  logic [1:0]                 i_bits,
    input  logic [dls_pkg::LIMB_W-1:0] i_divisor,
    output dls_pkg::t_step_res         o_res
);
    import dls_pkg::*;

    logic [LIMB_W:0]   w_t1;
    logic [LIMB_W:0]   w_t2;
    logic [LIMB_W:0]   w_d;
    logic [LIMB_W-1:0] w_a1;
    logic              w_q1;
    logic              w_q2;

    assign w_d  = {1'b0, i_divisor};
    assign w_t1 = {i_acc, i_bits[1]};
    assign w_q1 = (w_t1 >= w_d);
    // remainder stays below the divisor, so the low bits hold it
    assign w_a1 = w_q1 ? LIMB_W'(w_t1 - w_d) : w_t1[LIMB_W-1:0];

    assign w_t2 = {w_a1, i_bits[0]};
    assign w_q2 = (w_t2 >= w_d);

    always_comb begin
        o_res.qbits = {w_q1, w_q2};
        o_res.acc   = w_q2 ? LIMB_W'(w_t2 - w_d) : w_t2[LIMB_W-1:0];
    end

endmodule

[src/decimal_limb_short_division.sv]
// Top level of the base-10000 limb short divider with its APB divisor register.
// Divides a multi-limb base-10000 number, fed most significant limb first, by the
// divisor register (byte address 0, reset value 1). Each accepted word forms
// limb + remainder * 10000 and delivers the floor quotient limb (saturated at
// 16383), the running remainder, and the final flag; after a final limb the carried
// remainder is cleared so the next number starts from zero. A divisor of zero gives
// an all-ones quotient and a zero remainder. One word occupies the block from
// acceptance to the result register: S_MUL for the 14x14 multiply by 10000, S_ADD
// for the limb add, S_DIV in the shared two-bit restoring step unit (28 quotient
// bits), and S_DONE to load the result. o_in_stall is high for the whole of that
// time, so the next word is taken in the cycle after the load. The result
// register lets the next word be accepted while a finished result still waits
// on i_out_stall. Write the divisor only while idle.
module decimal_limb_short_division (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [dls_pkg::LIMB_W-1:0]    i_digit_limb,
    input  logic                          i_final_limb,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [dls_pkg::LIMB_W-1:0]    o_quotient_limb,
    output logic [dls_pkg::LIMB_W-1:0]    o_running_remainder,
    output logic                          o_final_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dls_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import dls_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic [LIMB_W-1:0]   r_divisor;
    logic [LIMB_W-1:0]   r_dvs;      // divisor held for the word in flight
    logic [LIMB_W-1:0]   r_rem;      // remainder carried to the next limb
    logic [LIMB_W-1:0]   r_limb;
    logic                r_last;
    logic [PART_W-1:0]   r_num;      // partial value, shifting into the quotient
    logic [LIMB_W-1:0]   r_acc;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_out_valid;
    logic [LIMB_W-1:0]   r_quo_out;
    logic [LIMB_W-1:0]   r_rem_out;
    logic                r_fin_out;

    logic                w_in_acc;
    logic                w_out_free;
    logic                w_cfg_wr;
    logic [PART_W-1:0]   w_prod;
    t_step_res           w_step;
    logic [LIMB_W-1:0]   w_quo;
    logic [LIMB_W-1:0]   w_rem;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr == ADDR_DIVISOR);
    assign prdata     = (paddr == ADDR_DIVISOR) ? {{(32-LIMB_W){1'b0}}, r_divisor} : '0;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    assign w_prod     = r_rem * LIMB_BASE;

    dls_step2 u_step (
        .i_acc     (r_acc),
        .i_bits    (r_num[PART_W-1 -: 2]),
        .i_divisor (r_dvs),
        .o_res     (w_step)
    );

    // saturate the quotient; a zero divisor forces all ones and a zero remainder
    always_comb begin
        if (r_dvs == '0) begin
            w_quo = LIMB_ONES;
            w_rem = '0;
        end else begin
            w_quo = (|r_num[PART_W-1:LIMB_W]) ? LIMB_ONES : r_num[LIMB_W-1:0];
            w_rem = r_acc;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_MUL;
            S_MUL:   n_state = S_ADD;
            S_ADD:   n_state = S_DIV;
            S_DIV:   if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_divisor   <= DIVISOR_RST;
            r_rem       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_divisor <= pwdata[LIMB_W-1:0];
            end
            // raise valid on a fresh load, drop it once the word is taken
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_DIV: begin
                    r_cnt <= (r_cnt == CNT_W'(DIV_STEPS - 1)) ? '0 : r_cnt + CNT_W'(1);
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_rem <= r_last ? '0 : w_rem;
                    end
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    // datapath: hold the word, multiply, add the limb, then iterate
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_limb <= i_digit_limb;
                    r_last <= i_final_limb;
                    r_dvs  <= r_divisor;
                end
            end
            S_MUL: begin
                r_num <= w_prod;
            end
            S_ADD: begin
                r_num <= r_num + PART_W'(r_limb);
                r_acc <= '0;
            end
            S_DIV: begin
                r_num <= {r_num[PART_W-3:0], w_step.qbits};
                r_acc <= w_step.acc;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_quo_out <= w_quo;
                    r_rem_out <= w_rem;
                    r_fin_out <= r_last;
                end
            end
            default: begin
                r_acc <= r_acc;
            end
        endcase
    end

    assign o_out_valid         = r_out_valid;
    assign o_quotient_limb     = r_quo_out;
    assign o_running_remainder = r_rem_out;
    assign o_final_result      = r_fin_out;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MUL))
        else $error("accepted word did not start the multiply");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc < r_dvs) || (r_dvs == '0))
        else $error("partial remainder not below divisor");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free && r_last) |=> (r_rem == '0) && o_out_valid)
        else $error("carried remainder not cleared after final limb");

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_cnt == '0))
        else $error("step counter not cleared when idle");

endmodule

[dv/testbench.sv]
// Self-checking testbench for the base-10000 limb short divider.
module testbench;
    import dls_pkg::*;

    typedef struct packed {
        logic [LIMB_W-1:0] quot;
        logic [LIMB_W-1:0] rem;
        logic              last;
    } t_quot_word;

    class limb_division_board;
        logic [LIMB_W-1:0] divisor;
        logic [LIMB_W-1:0] carry;
        t_quot_word        pending[$];
        int                errors;

        function new();
            divisor = DIVISOR_RST;
            carry   = '0;
            errors  = 0;
        endfunction

        function void load_divisor(logic [LIMB_W-1:0] value);
            divisor = value;
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            errors++;
            if (errors <= 10) begin
                $display("mismatch in %s: expected %0d, got %0d", what, want, got);
            end
        endfunction

        function void note_word(logic [LIMB_W-1:0] limb, logic last);
            logic [31:0] partial;
            logic [31:0] quot;
            t_quot_word  w;
            if (divisor == '0) begin
                w.quot = LIMB_ONES;
                w.rem  = '0;
            end else begin
                partial = 32'(limb) + 32'(carry) * 32'(LIMB_BASE);
                quot    = partial / 32'(divisor);
                w.rem   = LIMB_W'(partial % 32'(divisor));
                w.quot  = (quot > 32'(LIMB_ONES)) ? LIMB_ONES : LIMB_W'(quot);
            end
            w.last = last;
            pending.push_back(w);
            carry = last ? '0 : w.rem;
        endfunction

        function void check_word(logic [LIMB_W-1:0] quot, logic [LIMB_W-1:0] rem,
                                 logic last);
            t_quot_word want;
            if (pending.size() == 0) begin
                report("result word with nothing pending", 32'd0, 32'(quot));
                return;
            end
            want = pending.pop_front();
            if (quot !== want.quot) report("quotient limb", 32'(want.quot), 32'(quot));
            if (rem !== want.rem) report("running remainder", 32'(want.rem), 32'(rem));
            if (last !== want.last) report("final flag", 32'(want.last), 32'(last));
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [LIMB_W-1:0]    i_digit_limb;
    logic                 i_final_limb;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [LIMB_W-1:0]    o_quotient_limb;
    logic [LIMB_W-1:0]    o_running_remainder;
    logic                 o_final_result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Long stretch with no idling on either side while this is set.
    bit                   calm = 1'b0;
    int                   cycles = 0;
    limb_division_board   board;

    decimal_limb_short_division dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_digit_limb        (i_digit_limb),
        .i_final_limb        (i_final_limb),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_quotient_limb     (o_quotient_limb),
        .o_running_remainder (o_running_remainder),
        .o_final_result      (o_final_result),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiving side: stall at random, and check every word taken at this edge.
    // Outputs are read before the edge's updates land, so the values seen are
    // the ones the handshake actually moved.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_word(o_quotient_limb, o_running_remainder, o_final_result);
        end
        i_out_stall <= calm ? 1'b0 : ($urandom_range(99) < 26);
    end

    // Watchdog: give up well beyond the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one word and hold it until taken. Now and then drop valid for a
    // gap first, long enough at times to land on any phase of the divide.
    task automatic send_word(input logic [LIMB_W-1:0] limb, input logic last);
        if (!calm && $urandom_range(99) < 26) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_digit_limb <= limb;
        i_final_limb <= last;
        do @(posedge i_clk); while (o_in_stall);
        board.note_word(limb, last);
    endtask

    // Hold off the sender until every pending result is back, then let the
    // block settle before the register is touched.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the
    // edge where the access phase meets pready.
    task automatic write_divisor(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DIVISOR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.load_divisor(value[LIMB_W-1:0]);
    endtask

    // Mostly in-range limbs, with the edges and out-of-range limbs mixed in.
    function automatic logic [LIMB_W-1:0] pick_limb();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LIMB_W'(9999);
            2:       return LIMB_W'($urandom_range(10000, 16383));
            default: return LIMB_W'($urandom_range(9999));
        endcase
    endfunction

    function automatic logic [LIMB_W-1:0] pick_divisor();
        case ($urandom_range(9))
            0:       return '0;
            1:       return LIMB_W'(1);
            2:       return LIMB_W'(9999);
            3:       return LIMB_W'($urandom_range(10000, 16383));
            4, 5:    return LIMB_W'($urandom_range(2, 30));
            default: return LIMB_W'($urandom_range(1, 9999));
        endcase
    endfunction

    initial begin
        int          phase;
        int          sent;
        int          len;
        bit          cut;
        logic [31:0] upper;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_digit_limb = '0;
        i_final_limb = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        board        = new();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset divisor of one: remainder stays zero, quotient is the limb.
        send_word(LIMB_W'(0), 1'b0);
        send_word(LIMB_W'(9999), 1'b0);
        send_word(LIMB_W'(16383), 1'b1);

        // Largest legal divisor with the largest carried remainder.
        drain();
        write_divisor(32'd9999);
        send_word(LIMB_W'(9998), 1'b0);
        send_word(LIMB_W'(9999), 1'b0);
        send_word(LIMB_W'(16383), 1'b1);
        send_word(LIMB_W'(0), 1'b1);

        // Small divisor: large quotients without saturation.
        drain();
        write_divisor(32'd7);
        send_word(LIMB_W'(6), 1'b0);
        send_word(LIMB_W'(9999), 1'b0);
        send_word(LIMB_W'(16383), 1'b0);
        send_word(LIMB_W'(0), 1'b1);

        // Divide by zero: all-ones quotient, zero remainder.
        drain();
        write_divisor(32'd0);
        send_word(LIMB_W'(1234), 1'b0);
        send_word(LIMB_W'(16383), 1'b1);

        // Divisor above the legal range, then change it mid-number so the
        // carried remainder far exceeds the new divisor and the quotient saturates.
        drain();
        write_divisor(32'd16383);
        send_word(LIMB_W'(16383), 1'b0);
        send_word(LIMB_W'(16382), 1'b0);
        drain();
        write_divisor(32'd2);
        send_word(LIMB_W'(16383), 1'b0);
        send_word(LIMB_W'(5), 1'b1);

        // Random phases: each picks a divisor, then streams whole numbers of a
        // few limbs. Some phases stop mid-number so the carry meets a new divisor.
        for (phase = 0; phase < 9; phase++) begin
            drain();
            calm  <= (phase == 4);
            upper = {18'($urandom_range((1 << 18) - 1)), 14'd0};
            if ($urandom_range(3) != 0) upper = '0;
            write_divisor(upper | 32'(pick_divisor()));
            sent = 0;
            while (sent < 100) begin
                len = $urandom_range(1, 8);
                cut = ($urandom_range(5) == 0) && (sent + len >= 100);
                for (int k = 0; k < len; k++) begin
                    send_word(pick_limb(), (k == len - 1) && !cut);
                end
                sent += len;
            end
        end

        drain();
        calm <= 1'b0;
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
